// ===== sv/ptq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptq_pkg: shared types and codes of the priority task queue
// Command and status codes, request and response beats, and the per-cell
// entry and control types used along the cell chain.
// ----------------------------------------------------------------------------
package ptq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QCNT_W      = 5;
   localparam int HANDLE_W    = 16;
   localparam int PRIO_W      = 8;
   localparam int TASKS_W     = 16;

   localparam logic [1:0] CMD_SUBMIT   = 2'd0;
   localparam logic [1:0] CMD_TAKE     = 2'd1;
   localparam logic [1:0] CMD_COMPLETE = 2'd2;
   localparam logic [1:0] CMD_STOP     = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_EMPTY   = 3'd2;
   localparam logic [2:0] ST_STOPPED = 3'd3;
   localparam logic [2:0] ST_INVALID = 3'd4;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [HANDLE_W-1:0] task_handle;
      logic [PRIO_W-1:0]   task_priority;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [HANDLE_W-1:0] out_handle;
      logic [PRIO_W-1:0]   out_priority;
      logic                active;
      logic                cancelled;
      logic [QCNT_W-1:0]   queued_count;
   } rsp_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [PRIO_W-1:0]   prio;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   item;
   } cell_ctl_type;

endpackage : ptq_pkg
`default_nettype wire

// ===== sv/ptq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptq_cell: one slot of the priority queue chain
// Holds one entry. On insert, a cell whose entry ranks below the new one
// (or that is empty) takes the new entry or its left neighbor's; on pop,
// every cell takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module ptq_cell
   import ptq_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire logic         occupied,
   input  wire logic         left_yield,
   input  wire entry_type    left_entry,
   input  wire entry_type    right_entry,
   output logic              yield,
   output entry_type         entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // strictly lower priority yields, so equal priorities keep arrival order
   assign yield = !occupied || (ctl.item.prio > entry_ff.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            if (yield && left_yield) begin
               entry_in = left_entry;
            end else if (yield) begin
               entry_in = ctl.item;
            end
         end
         CELL_POP: entry_in = right_entry;
         default:  entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule : ptq_cell
`default_nettype wire

// ===== sv/priority_task_queue_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// priority_task_queue_unit: priority-ordered task dispatcher
// Command-driven queue of task handles kept in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Present a command beat on req_item with start high; it is taken at any
//   rising edge where start is high and busy is low. busy stays low, so one
//   command can be taken every cycle.
//   Each command produces exactly one response beat on rsp_item, marked by
//   rsp_strobe for one cycle, in the cycle right after the command was taken.
//   Every cell compares the incoming priority with its own entry in parallel,
//   so an insert or a pop updates the whole chain at once, regardless of
//   queue depth.
//   Submit inserts behind all entries of equal or higher priority; take pops
//   the head; complete lowers the outstanding count; stop blocks further
//   takes and sets the cancelled flag.
//   The response cannot be stalled: it must be captured on the strobe.
//   Synchronous reset empties the queue, clears the outstanding count and
//   both flags; entry contents are left as they are and never read while
//   outside the filled range.
// ----------------------------------------------------------------------------
module priority_task_queue_unit
   import ptq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_item,
   output logic         busy,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [TASKS_W-1:0] tasks_ff, tasks_in;
   logic               stop_ff, stop_in;
   logic               cancel_ff, cancel_in;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   cell_ctl_type       ctl;
   logic [QUEUE_DEPTH-1:0] yield;
   logic [QUEUE_DEPTH-1:0] occupied;
   entry_type          entries [QUEUE_DEPTH];
   entry_type          blank_entry;

   assign busy       = 1'b0;
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;
   assign blank_entry = '0;

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         assign occupied[gi] = fill_ff > FILL_W'(gi);
         ptq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occupied[gi]),
            .left_yield  ((gi == 0) ? 1'b0 : yield[(gi == 0) ? 0 : gi - 1]),
            .left_entry  ((gi == 0) ? blank_entry : entries[(gi == 0) ? 0 : gi - 1]),
            .right_entry ((gi == QUEUE_DEPTH - 1) ? blank_entry
                          : entries[(gi == QUEUE_DEPTH - 1) ? gi : gi + 1]),
            .yield       (yield[gi]),
            .entry       (entries[gi])
         );
      end
   endgenerate

   always_comb begin
      fill_in    = fill_ff;
      tasks_in   = tasks_ff;
      stop_in    = stop_ff;
      cancel_in  = cancel_ff;
      ctl.op     = CELL_HOLD;
      ctl.item.handle = req_item.task_handle;
      ctl.item.prio   = req_item.task_priority;
      rsp_in     = '0;
      rsp_in.status = ST_OK;
      if (accept) begin
         unique case (req_item.cmd)
            CMD_SUBMIT: begin
               if (req_item.task_handle == '0) begin
                  rsp_in.status = ST_INVALID;
               end else if (fill_ff == FILL_W'(QUEUE_DEPTH)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  ctl.op  = CELL_INSERT;
                  fill_in = fill_ff + 1'b1;
                  if (tasks_ff != '1) begin
                     tasks_in = tasks_ff + 1'b1;
                  end
               end
            end
            CMD_TAKE: begin
               if (stop_ff) begin
                  rsp_in.status = ST_STOPPED;
               end else if (fill_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  ctl.op  = CELL_POP;
                  fill_in = fill_ff - 1'b1;
                  rsp_in.out_handle   = entries[0].handle;
                  rsp_in.out_priority = entries[0].prio;
               end
            end
            CMD_COMPLETE: begin
               if (tasks_ff != '0) begin
                  tasks_in = tasks_ff - 1'b1;
               end
            end
            CMD_STOP: begin
               stop_in   = 1'b1;
               cancel_in = 1'b1;
            end
            default: ;
         endcase
      end
      rsp_in.active       = tasks_in != '0;
      rsp_in.cancelled    = cancel_in;
      rsp_in.queued_count = QCNT_W'(fill_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         tasks_ff      <= '0;
         stop_ff       <= 1'b0;
         cancel_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         tasks_ff      <= tasks_in;
         stop_ff       <= stop_in;
         cancel_ff     <= cancel_in;
         rsp_strobe_ff <= accept;
      end
      rsp_ff <= rsp_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("queue fill above depth");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("missing response beat");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (fill_ff == $past(fill_ff) || fill_ff == $past(fill_ff) + 1'b1
                         || fill_ff == $past(fill_ff) - 1'b1))
      else $error("fill moved by more than one");

   a_take_nonzero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.cmd == CMD_TAKE && !stop_ff && fill_ff != '0)
      |=> (rsp_item.out_handle != '0 && rsp_item.status == ST_OK))
      else $error("popped entry carries no handle");

endmodule : priority_task_queue_unit
`default_nettype wire
